>>> rtl/core/second_harmonic_event_plane_defines.svh
// Assertion helpers for the event-plane core.
`ifndef SECOND_HARMONIC_EVENT_PLANE_DEFINES_SVH
`define SECOND_HARMONIC_EVENT_PLANE_DEFINES_SVH

// condition must hold at every edge out of reset
`define SHEP_ASSERT_ALWAYS(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// consequent must hold in the same cycle as the antecedent
`define SHEP_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

`endif

>>> rtl/core/shep_pkg.sv
package shep_pkg;

   localparam int ANGLE_BITS    = 16;
   localparam int MAX_PARTICLES = 4096;
   localparam int ATAN_LEN      = 24;
   localparam int STAGES        = (ANGLE_BITS < ATAN_LEN) ? ANGLE_BITS : ATAN_LEN;

   localparam int PHI_W   = 16;
   localparam int PLANE_W = 16;
   localparam int IDX_W   = 5;    // covers shifts up to ATAN_LEN-1
   localparam int CS_W    = 26;   // sin/cos datapath, 8 extra fraction bits
   localparam int RZ_W    = 33;   // rotation residual angle
   localparam int TRIG_W  = 17;   // Q1.15 plus room for negated -32768
   localparam int SUM_W   = 32;
   localparam int VEC_W   = SUM_W + 19;  // sums scaled by 2^16 plus CORDIC growth
   localparam int VZ_W    = 34;

   localparam int COS_START = 19896;

   localparam logic signed [SUM_W:0] SUM_BOUND = (SUM_W+1)'(MAX_PARTICLES * 32767);
   localparam logic signed [VZ_W-1:0] HALF_TURN = VZ_W'(64'sh8000_0000);

   typedef struct packed {
      logic                    last;
      logic                    flip;
      logic signed [CS_W-1:0]  x;
      logic signed [CS_W-1:0]  y;
      logic signed [RZ_W-1:0]  z;
   } rot_data_type;

   typedef struct packed {
      logic                    empty;
      logic signed [VEC_W-1:0] x;
      logic signed [VEC_W-1:0] y;
      logic signed [VZ_W-1:0]  z;
   } vec_data_type;

   // atan(2^-i) in turn units, 2^32 = one turn
   function automatic logic [31:0] atan_turn(input logic [IDX_W-1:0] idx);
      logic [31:0] a;
      unique case (idx)
         5'd0:    a = 32'h2000_0000;
         5'd1:    a = 32'h12E4_051E;
         5'd2:    a = 32'h09FB_385B;
         5'd3:    a = 32'h0511_11D4;
         5'd4:    a = 32'h028B_0D43;
         5'd5:    a = 32'h0145_D7E1;
         5'd6:    a = 32'h00A2_F61E;
         5'd7:    a = 32'h0051_7C55;
         5'd8:    a = 32'h0028_BE53;
         5'd9:    a = 32'h0014_5F2F;
         5'd10:   a = 32'h000A_2F98;
         5'd11:   a = 32'h0005_17CC;
         5'd12:   a = 32'h0002_8BE6;
         5'd13:   a = 32'h0001_45F3;
         5'd14:   a = 32'h0000_A2FA;
         5'd15:   a = 32'h0000_517D;
         5'd16:   a = 32'h0000_28BE;
         5'd17:   a = 32'h0000_145F;
         5'd18:   a = 32'h0000_0A30;
         5'd19:   a = 32'h0000_0518;
         5'd20:   a = 32'h0000_028C;
         5'd21:   a = 32'h0000_0146;
         5'd22:   a = 32'h0000_00A3;
         5'd23:   a = 32'h0000_0051;
         default: a = 32'h0000_0000;
      endcase
      return a;
   endfunction

endpackage

>>> rtl/core/shep_rot_cell.sv
// One rotation-mode CORDIC micro-rotation, registered.
module shep_rot_cell import shep_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               advance,
   input  logic [IDX_W-1:0]   stage_idx,
   input  logic               in_valid,
   input  rot_data_type       in_data,
   output logic               out_valid,
   output rot_data_type       out_data
);

   logic                   valid_ff;
   rot_data_type           data_ff;
   rot_data_type           data_in;
   logic signed [RZ_W-1:0] atan;

   always_comb begin
      atan    = RZ_W'($signed({1'b0, atan_turn(stage_idx)}));
      data_in = in_data;
      if (!in_data.z[RZ_W-1]) begin
         data_in.x = in_data.x - (in_data.y >>> stage_idx);
         data_in.y = in_data.y + (in_data.x >>> stage_idx);
         data_in.z = in_data.z - atan;
      end else begin
         data_in.x = in_data.x + (in_data.y >>> stage_idx);
         data_in.y = in_data.y - (in_data.x >>> stage_idx);
         data_in.z = in_data.z + atan;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

>>> rtl/core/shep_vec_cell.sv
// One vectoring-mode CORDIC micro-rotation, registered.
module shep_vec_cell import shep_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               advance,
   input  logic [IDX_W-1:0]   stage_idx,
   input  logic               in_valid,
   input  vec_data_type       in_data,
   output logic               out_valid,
   output vec_data_type       out_data
);

   logic                   valid_ff;
   vec_data_type           data_ff;
   vec_data_type           data_in;
   logic signed [VZ_W-1:0] atan;

   always_comb begin
      atan    = VZ_W'($signed({1'b0, atan_turn(stage_idx)}));
      data_in = in_data;
      // drive y toward zero
      if (!in_data.y[VEC_W-1] && (in_data.y != '0)) begin
         data_in.x = in_data.x + (in_data.y >>> stage_idx);
         data_in.y = in_data.y - (in_data.x >>> stage_idx);
         data_in.z = in_data.z + atan;
      end else begin
         data_in.x = in_data.x - (in_data.y >>> stage_idx);
         data_in.y = in_data.y + (in_data.x >>> stage_idx);
         data_in.z = in_data.z - atan;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

>>> rtl/core/second_harmonic_event_plane.sv
// Second-harmonic event plane: one azimuth per unheld cycle, result on the last particle.
// Throughput: one transaction per unheld cycle, set by the two pipelined CORDIC chains.
// Path to rsp_valid: sin/cos cells, trig and snapshot registers, atan2 cells, output.
// The whole pipe holds only while a new result meets an output register still stalled.
// Reset (synchronous, active high) empties the pipe and clears both Q-vector sums.
`include "second_harmonic_event_plane_defines.svh"

module second_harmonic_event_plane import shep_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   // particle transactions
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic [PHI_W-1:0]          req_phi_angle,
   input  logic                      req_last_particle,
   // event-plane transactions
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic signed [PLANE_W-1:0] rsp_plane_angle,
   output logic                      rsp_empty_q_vector
);

   // ------------------------------------------------------------------
   // Flow control. Every stage moves on "advance". The only hold case is
   // a finished result reaching the output register while the previous
   // result there is still stalled; otherwise particles keep flowing.
   // ------------------------------------------------------------------
   logic advance;
   logic vec_tail_valid;

   assign advance   = !(rsp_valid && rsp_stall && vec_tail_valid);
   assign req_stall = !advance;

   // ------------------------------------------------------------------
   // Sin/cos chain. Doubled angle in turn units is {phi[14:0], 17'b0};
   // quadrants 1 and 2 fold by a half turn (top bit flip) and negate
   // the result at the end.
   // ------------------------------------------------------------------
   rot_data_type rot_link [STAGES+1];
   logic         rot_vld  [STAGES+1];

   always_comb begin
      rot_link[0].last = req_last_particle;
      rot_link[0].flip = req_phi_angle[PHI_W-2] ^ req_phi_angle[PHI_W-3];
      rot_link[0].x    = CS_W'(COS_START * 256);
      rot_link[0].y    = '0;
      rot_link[0].z    = RZ_W'($signed({req_phi_angle[PHI_W-3],
                                         req_phi_angle[PHI_W-3:0], 17'b0}));
   end
   // top bit after the fold: phi[14] ^ flip == phi[13]
   assign rot_vld[0] = req_valid;

   for (genvar k = 0; k < STAGES; k++) begin : g_rot
      shep_rot_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .advance   (advance),
         .stage_idx (IDX_W'(k)),
         .in_valid  (rot_vld[k]),
         .in_data   (rot_link[k]),
         .out_valid (rot_vld[k+1]),
         .out_data  (rot_link[k+1])
      );
   end

   // ------------------------------------------------------------------
   // Round to Q1.15, clamp, undo the half-turn fold.
   // ------------------------------------------------------------------
   function automatic logic signed [TRIG_W-1:0] round_trig(
      input logic signed [CS_W-1:0] v,
      input logic                   neg
   );
      logic signed [CS_W:0]     r;
      logic signed [TRIG_W-1:0] lim;
      r = ((CS_W+1)'(v) + (CS_W+1)'(128)) >>> 8;
      if (r > 32767) begin
         lim = TRIG_W'(32767);
      end else if (r < -32768) begin
         lim = -TRIG_W'(32768);
      end else begin
         lim = TRIG_W'(r);
      end
      return neg ? -lim : lim;
   endfunction

   logic                     trig_valid_ff;
   logic                     trig_last_ff;
   logic signed [TRIG_W-1:0] cos_trig_ff;
   logic signed [TRIG_W-1:0] sin_trig_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         trig_valid_ff <= 1'b0;
      end else if (advance) begin
         trig_valid_ff <= rot_vld[STAGES];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         trig_last_ff <= rot_link[STAGES].last;
         cos_trig_ff  <= round_trig(rot_link[STAGES].x, rot_link[STAGES].flip);
         sin_trig_ff  <= round_trig(rot_link[STAGES].y, rot_link[STAGES].flip);
      end
   end

   // ------------------------------------------------------------------
   // Q-vector accumulators, saturating at +-MAX_PARTICLES*32767.
   // The last particle is added first, the totals go to the snapshot
   // register and the sums clear.
   // ------------------------------------------------------------------
   function automatic logic signed [SUM_W-1:0] sat_add(
      input logic signed [SUM_W-1:0]  s,
      input logic signed [TRIG_W-1:0] t
   );
      logic signed [SUM_W:0] w;
      w = (SUM_W+1)'(s) + (SUM_W+1)'(t);
      if (w > SUM_BOUND) begin
         w = SUM_BOUND;
      end else if (w < -SUM_BOUND) begin
         w = -SUM_BOUND;
      end
      return SUM_W'(w);
   endfunction

   logic signed [SUM_W-1:0] cos_sum_ff, cos_sum_in;
   logic signed [SUM_W-1:0] sin_sum_ff, sin_sum_in;
   logic signed [SUM_W-1:0] cos_total, sin_total;
   logic                    snap_valid_ff;
   logic signed [SUM_W-1:0] snap_cos_ff;
   logic signed [SUM_W-1:0] snap_sin_ff;

   always_comb begin
      cos_total  = sat_add(cos_sum_ff, cos_trig_ff);
      sin_total  = sat_add(sin_sum_ff, sin_trig_ff);
      cos_sum_in = cos_sum_ff;
      sin_sum_in = sin_sum_ff;
      if (advance && trig_valid_ff) begin
         cos_sum_in = trig_last_ff ? '0 : cos_total;
         sin_sum_in = trig_last_ff ? '0 : sin_total;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cos_sum_ff    <= '0;
         sin_sum_ff    <= '0;
         snap_valid_ff <= 1'b0;
      end else begin
         cos_sum_ff <= cos_sum_in;
         sin_sum_ff <= sin_sum_in;
         if (advance) begin
            snap_valid_ff <= trig_valid_ff && trig_last_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         snap_cos_ff <= cos_total;
         snap_sin_ff <= sin_total;
      end
   end

   // ------------------------------------------------------------------
   // atan2 chain. Sums scaled by 2^16; a negative cos sum folds by a
   // half turn (sign follows the sin sum, zero counts as positive).
   // ------------------------------------------------------------------
   vec_data_type vec_link [STAGES+1];
   logic         vec_vld  [STAGES+1];

   always_comb begin
      vec_link[0].empty = (snap_cos_ff == '0) && (snap_sin_ff == '0);
      vec_link[0].x     = VEC_W'(snap_cos_ff) <<< 16;
      vec_link[0].y     = VEC_W'(snap_sin_ff) <<< 16;
      vec_link[0].z     = '0;
      if (snap_cos_ff[SUM_W-1]) begin
         vec_link[0].x = -(VEC_W'(snap_cos_ff) <<< 16);
         vec_link[0].y = -(VEC_W'(snap_sin_ff) <<< 16);
         vec_link[0].z = snap_sin_ff[SUM_W-1] ? -HALF_TURN : HALF_TURN;
      end
   end
   assign vec_vld[0] = snap_valid_ff;

   for (genvar k = 0; k < STAGES; k++) begin : g_vec
      shep_vec_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .advance   (advance),
         .stage_idx (IDX_W'(k)),
         .in_valid  (vec_vld[k]),
         .in_data   (vec_link[k]),
         .out_valid (vec_vld[k+1]),
         .out_data  (vec_link[k+1])
      );
   end

   assign vec_tail_valid = vec_vld[STAGES];

   // ------------------------------------------------------------------
   // Halve the angle with rounding, map to signed quarter-turn range.
   // ------------------------------------------------------------------
   logic signed [VZ_W-1:0]    half_z;
   logic signed [PLANE_W-1:0] plane_in;

   always_comb begin
      half_z = (vec_link[STAGES].z + VZ_W'(65536)) >>> 17;
      if (vec_link[STAGES].empty) begin
         plane_in = '0;
      end else if (half_z > 16384) begin
         plane_in = PLANE_W'(16384);
      end else if (half_z < -16384) begin
         plane_in = -PLANE_W'(16384);
      end else begin
         plane_in = PLANE_W'(half_z);
      end
   end

   // ------------------------------------------------------------------
   // Output register: loads a new result, or empties once taken.
   // ------------------------------------------------------------------
   logic                      rsp_valid_ff;
   logic signed [PLANE_W-1:0] rsp_plane_angle_ff;
   logic                      rsp_empty_ff;
   logic                      rsp_load;

   assign rsp_load = advance && vec_tail_valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_plane_angle_ff <= plane_in;
         rsp_empty_ff       <= vec_link[STAGES].empty;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_plane_angle    = rsp_plane_angle_ff;
   assign rsp_empty_q_vector = rsp_empty_ff;

   // ------------------------------------------------------------------
   // Checks
   // ------------------------------------------------------------------
   logic empty_rsp;
   logic zero_angle;
   logic plane_ok;
   logic rsp_blocked;
   logic sums_ok;

   assign empty_rsp   = rsp_valid && rsp_empty_q_vector;
   assign zero_angle  = (rsp_plane_angle == '0);
   assign plane_ok    = (rsp_plane_angle <= 16384) && (rsp_plane_angle >= -16384);
   assign rsp_blocked = rsp_valid && rsp_stall;
   assign sums_ok     = ((SUM_W+1)'(cos_sum_ff) <= SUM_BOUND)
                     && ((SUM_W+1)'(cos_sum_ff) >= -SUM_BOUND)
                     && ((SUM_W+1)'(sin_sum_ff) <= SUM_BOUND)
                     && ((SUM_W+1)'(sin_sum_ff) >= -SUM_BOUND);

   `SHEP_ASSERT_IMPLY(a_empty_zero, clock, reset, empty_rsp, zero_angle, "nonzero empty angle")
   `SHEP_ASSERT_IMPLY(a_plane_range, clock, reset, rsp_valid, plane_ok, "angle out of range")
   `SHEP_ASSERT_IMPLY(a_stall_cause, clock, reset, req_stall, rsp_blocked, "stall without cause")
   `SHEP_ASSERT_ALWAYS(a_sum_bound, clock, reset, sums_ok, "Q-vector sum out of bound")

endmodule

>>> test/second_harmonic_event_plane_test.sv
`timescale 1ns / 1ps

// One expected event-plane transaction.
typedef struct packed {
   logic signed [shep_pkg::PLANE_W-1:0] angle;
   logic                                empty;
} event_plane_type;

// Q-vector scoreboard: keeps its own cos/sin sums and predicts the plane on each last particle.
class event_plane_board;
   event_plane_type expected_planes[$];
   longint       q_cos;
   longint       q_sin;
   int           failures;
   int           particles;
   int           collections;
   int           empties;
   int           clipped;

   function longint clip(longint v, longint lo, longint hi);
      return (v < lo) ? lo : ((v > hi) ? hi : v);
   endfunction

   // atan(2^-i) in turn units, 2^32 = one turn
   function longint turn_atan(int i);
      case (i)
         0:       return 64'h2000_0000;
         1:       return 64'h12E4_051E;
         2:       return 64'h09FB_385B;
         3:       return 64'h0511_11D4;
         4:       return 64'h028B_0D43;
         5:       return 64'h0145_D7E1;
         6:       return 64'h00A2_F61E;
         7:       return 64'h0051_7C55;
         8:       return 64'h0028_BE53;
         9:       return 64'h0014_5F2F;
         10:      return 64'h000A_2F98;
         11:      return 64'h0005_17CC;
         12:      return 64'h0002_8BE6;
         13:      return 64'h0001_45F3;
         14:      return 64'h0000_A2FA;
         15:      return 64'h0000_517D;
         16:      return 64'h0000_28BE;
         17:      return 64'h0000_145F;
         18:      return 64'h0000_0A30;
         19:      return 64'h0000_0518;
         20:      return 64'h0000_028C;
         21:      return 64'h0000_0146;
         22:      return 64'h0000_00A3;
         23:      return 64'h0000_0051;
         default: return 64'h0;
      endcase
   endfunction

   // rotation CORDIC, Q1.15 cosine and sine of a 32-bit turn angle
   function void trig_of(input logic [31:0] turn, output longint c, output longint s);
      logic   flip;
      longint x;
      longint y;
      longint z;
      longint nx;
      flip = (turn[31:30] == 2'd1) || (turn[31:30] == 2'd2);
      if (flip) begin
         turn = turn + 32'h8000_0000;
      end
      z = $signed(turn);
      x = 64'sd19896 * 256;
      y = 0;
      for (int i = 0; i < shep_pkg::STAGES; i++) begin
         if (z >= 0) begin
            nx = x - (y >>> i);
            y  = y + (x >>> i);
            z  = z - turn_atan(i);
         end else begin
            nx = x + (y >>> i);
            y  = y - (x >>> i);
            z  = z + turn_atan(i);
         end
         x = nx;
      end
      x = clip((x + 128) >>> 8, -32768, 32767);
      y = clip((y + 128) >>> 8, -32768, 32767);
      c = flip ? -x : x;
      s = flip ? -y : y;
   endfunction

   // vectoring CORDIC, half of atan2 in units of 16384 = quarter turn
   function longint half_angle(longint ys, longint xs);
      longint x;
      longint y;
      longint z;
      longint nx;
      x = xs * 65536;
      y = ys * 65536;
      z = 0;
      if (x < 0) begin
         z = (y >= 0) ? 64'sh8000_0000 : -64'sh8000_0000;
         x = -x;
         y = -y;
      end
      for (int i = 0; i < shep_pkg::STAGES; i++) begin
         if (y > 0) begin
            nx = x + (y >>> i);
            y  = y - (x >>> i);
            z  = z + turn_atan(i);
         end else begin
            nx = x - (y >>> i);
            y  = y + (x >>> i);
            z  = z - turn_atan(i);
         end
         x = nx;
      end
      return clip((z + 65536) >>> 17, -16384, 16384);
   endfunction

   function void note_particle(logic [15:0] phi, logic is_last);
      logic [15:0]     doubled;
      longint          c;
      longint          s;
      longint          bound;
      event_plane_type want;
      doubled = phi << 1;
      trig_of({doubled, 16'h0000}, c, s);
      bound = longint'(shep_pkg::MAX_PARTICLES) * 32767;
      if (q_cos + c > bound || q_cos + c < -bound) clipped++;
      if (q_sin + s > bound || q_sin + s < -bound) clipped++;
      q_cos = clip(q_cos + c, -bound, bound);
      q_sin = clip(q_sin + s, -bound, bound);
      particles++;
      if (!is_last) return;
      want.empty = (q_cos == 0) && (q_sin == 0);
      want.angle = want.empty ? '0 : 16'(half_angle(q_sin, q_cos));
      expected_planes = {expected_planes, want};
      collections++;
      if (want.empty) empties++;
      q_cos = 0;
      q_sin = 0;
   endfunction

   function void check_plane(logic signed [15:0] angle, logic empty);
      event_plane_type want;
      if (expected_planes.size() == 0) begin
         $error("event plane transaction with none expected: plane_angle %0d", angle);
         failures++;
         return;
      end
      want = expected_planes.pop_front();
      if (angle !== want.angle) begin
         $error("plane_angle: expected %0d, got %0d", want.angle, angle);
         failures++;
      end
      if (empty !== want.empty) begin
         $error("empty_q_vector: expected %0d, got %0d", want.empty, empty);
         failures++;
      end
   endfunction
endclass

module second_harmonic_event_plane_test;
   import shep_pkg::*;

   // pipe latency from the last particle to its result, plus margin for the drain
   localparam int DRAIN_CYCLES = 2 * STAGES + 3 + 40;
   // cycle limit for the whole run, enforced by the watchdog
   localparam int CYCLE_LIMIT  = 20000;
   localparam int RANDOM_ITEMS = 300;
   localparam int BURST_LEN    = 24;

   logic                      clock;
   logic                      reset;
   logic                      req_valid;
   logic                      req_stall;
   logic [PHI_W-1:0]          req_phi_angle;
   logic                      req_last_particle;
   logic                      rsp_valid;
   logic                      rsp_stall;
   logic signed [PLANE_W-1:0] rsp_plane_angle;
   logic                      rsp_empty_q_vector;

   // gaps_on gates random idling on both channels; cleared for a quiet stretch
   logic                      gaps_on;
   int                        cycle_count;
   int                        random_sent;
   event_plane_board          board;

   second_harmonic_event_plane uut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_phi_angle      (req_phi_angle),
      .req_last_particle  (req_last_particle),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_plane_angle    (rsp_plane_angle),
      .rsp_empty_q_vector (rsp_empty_q_vector)
   );

   always #10 clock = ~clock;

   // Receiver: random stall about 6% of cycles, changed on the falling edge only.
   always @(negedge clock) begin
      rsp_stall <= gaps_on && ($urandom_range(99) < 6);
   end

   // Result side: compare each accepted event-plane transaction with the oldest prediction.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         board.check_plane(rsp_plane_angle, rsp_empty_q_vector);
      end
   end

   // Watchdog: a hung pipe or a lost result ends the run here.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("second_harmonic_event_plane_test failed");
         $finish;
      end
   end

   // Drive one particle transaction. Entered and left on a falling edge; valid stays
   // high on return, so the caller either sends again or drops valid at that edge.
   task automatic send_particle(input logic [15:0] phi, input logic is_last);
      while (gaps_on && ($urandom_range(99) < 6)) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid         <= 1'b1;
      req_phi_angle     <= phi;
      req_last_particle <= is_last;
      do @(posedge clock); while (req_stall);
      board.note_particle(phi, is_last);
      @(negedge clock);
   endtask

   // A run of identical particles; builds a large Q vector along one direction.
   task automatic send_run(input logic [15:0] phi, input int count, input logic close);
      for (int k = 0; k < count; k++) begin
         send_particle(phi, close && (k == count - 1));
      end
   endtask

   // One collection of particles clustered around a random direction; a wide
   // spread gives near-isotropic collections with small Q vectors.
   task automatic send_collection(input int n);
      logic [15:0] base;
      int          spread;
      base = 16'($urandom_range(65535));
      case ($urandom_range(2))
         0:       spread = 255;
         1:       spread = 4095;
         default: spread = 65535;
      endcase
      for (int k = 0; k < n; k++) begin
         send_particle(base + 16'($urandom_range(spread)), k == n - 1);
      end
   endtask

   initial begin
      board             = new();
      clock             = 1'b0;
      reset             = 1'b1;
      req_valid         = 1'b0;
      req_phi_angle     = '0;
      req_last_particle = 1'b0;
      rsp_stall         = 1'b0;
      gaps_on           = 1'b1;
      cycle_count       = 0;
      random_sent       = 0;

      repeat (7) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed: single-particle collections at the angle extremes and quadrant edges.
      send_particle(16'd0, 1'b1);
      send_particle(16'd65535, 1'b1);
      send_particle(16'd1, 1'b1);
      send_particle(16'd8192, 1'b1);
      send_particle(16'd24576, 1'b1);
      send_particle(16'd40960, 1'b1);
      send_particle(16'd57344, 1'b1);
      // doubled angle of a half turn: negative cos sum with zero sin sum
      send_particle(16'd16384, 1'b1);
      // opposite doubled angles cancel exactly: empty Q vector
      send_particle(16'd0, 1'b0);
      send_particle(16'd16384, 1'b1);
      // two-particle collection across the half-turn boundary
      send_particle(16'd32767, 1'b0);
      send_particle(16'd32768, 1'b1);
      // four doubled quadrants in one collection
      send_particle(16'd0, 1'b0);
      send_particle(16'd8192, 1'b0);
      send_particle(16'd16384, 1'b0);
      send_particle(16'd24576, 1'b1);

      // Long runs: positive cos then positive sin, then both negative.
      send_run(16'd0, BURST_LEN, 1'b0);
      send_run(16'd8192, BURST_LEN, 1'b1);
      send_run(16'd16384, BURST_LEN, 1'b0);
      send_run(16'd24576, BURST_LEN, 1'b1);

      // Random collections; a quiet stretch with no idling, then one full drain
      // of the pipe with the sender held off.
      while (random_sent < RANDOM_ITEMS) begin
         automatic int n = ($urandom_range(9) == 0) ? 1 : $urandom_range(2, 16);
         gaps_on = !(random_sent >= 120 && random_sent < 220);
         if (random_sent >= 260 && random_sent < 280) begin
            req_valid <= 1'b0;
            while (board.expected_planes.size() != 0) @(negedge clock);
            random_sent = 280;
         end
         send_collection(n);
         random_sent += n;
      end
      gaps_on   = 1'b1;
      req_valid <= 1'b0;

      while (board.expected_planes.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Covered %0d particles in %0d collections, %0d of them with an empty Q vector,",
               board.particles, board.collections, board.empties);
      $display("and %0d saturated accumulator updates under random stall on both sides.",
               board.clipped);
      if (board.failures == 0) begin
         $display("second_harmonic_event_plane_test passed");
      end else begin
         $display("second_harmonic_event_plane_test failed");
      end
      $finish;
   end

endmodule
